[design/afd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afd_pkg
// Shared constants, types and helpers for the API frame deframer.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] SUM_TARGET = 8'hFF;

  // parse phase codes; 5..7 behave as hunting
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_LENHI = 3'd1;
  localparam logic [2:0] PH_LENLO = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_CSUM  = 3'd4;

  // end-of-frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // frame type codes the receiver recognizes
  localparam logic [7:0] FT_AT_RESP     = 8'h88;
  localparam logic [7:0] FT_TX_STAT_OLD = 8'h89;
  localparam logic [7:0] FT_MODEM_STAT  = 8'h8A;
  localparam logic [7:0] FT_TX_STAT     = 8'h8B;
  localparam logic [7:0] FT_RX_PKT      = 8'h90;
  localparam logic [7:0] FT_RX_PKT_EXPL = 8'h91;
  localparam logic [7:0] FT_REMOTE_AT   = 8'h97;

  // received word held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_word_t;

  function automatic logic kind_known(input logic [7:0] k);
    logic known;
    known = 1'b0;
    case (k) inside
      FT_AT_RESP, FT_TX_STAT_OLD, FT_MODEM_STAT, FT_TX_STAT,
      FT_RX_PKT, FT_RX_PKT_EXPL, FT_REMOTE_AT: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage
`default_nettype wire

[design/afd_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afd_byte_if
// Valid/ready channel carrying one received serial byte per word.
// ----------------------------------------------------------------------------
interface afd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[design/afd_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afd_result_if
// Valid/ready channel carrying one body byte or end-of-frame status per word.
// ----------------------------------------------------------------------------
interface afd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic        frame_end;
  logic [1:0]  frame_status;

  modport source (output valid, output data_byte, output byte_index,
                  output frame_end, output frame_status, input ready);
  modport sink   (input valid, input data_byte, input byte_index,
                  input frame_end, input frame_status, output ready);
endinterface
`default_nettype wire

[design/afd_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afd_in_stage
// Input register: captures one received byte and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module afd_in_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  afd_byte_if.sink          rx,
  input  wire logic         advance,
  output afd_pkg::byte_word_t word
);

  logic       valid;
  logic [7:0] rx_byte;

  // take a new word when empty or when the held one leaves this cycle
  assign rx.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.ready) begin
      valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      rx_byte <= rx.rx_byte;
    end
  end

  assign word.valid   = valid;
  assign word.rx_byte = rx_byte;

endmodule
`default_nettype wire

[design/afd_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afd_parser
// Frame state machine, running checksum and result register.
// ----------------------------------------------------------------------------
module afd_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire afd_pkg::byte_word_t word,
  output logic                     advance,
  afd_result_if.source             res
);

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [15:0] frame_length;
  logic [15:0] frame_length_next;
  logic [15:0] body_count;
  logic [15:0] body_count_next;
  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;
  logic [7:0]  frame_kind;
  logic [7:0]  frame_kind_next;

  logic        has_result;
  logic        end_result;
  logic [1:0]  status;
  logic [7:0]  b;
  logic [15:0] count_inc;
  logic [15:0] full_length;

  logic        out_valid;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic        frame_end;
  logic [1:0]  frame_status;

  // consume the held word once the result register can take a result
  assign advance     = word.valid && (!out_valid || res.ready);
  assign b           = word.rx_byte;
  assign count_inc   = body_count + 16'd1;
  assign full_length = {frame_length[15:8], b};

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    body_count_next   = body_count;
    running_sum_next  = running_sum;
    frame_kind_next   = frame_kind;
    has_result        = 1'b0;
    end_result        = 1'b0;
    status            = afd_pkg::ST_OK;
    unique case (phase)
      afd_pkg::PH_LENHI: begin
        frame_length_next = {b, 8'h00};
        phase_next        = afd_pkg::PH_LENLO;
      end
      afd_pkg::PH_LENLO: begin
        frame_length_next = full_length;
        body_count_next   = '0;
        running_sum_next  = '0;
        frame_kind_next   = '0;
        phase_next        = (full_length == 16'd0) ? afd_pkg::PH_CSUM : afd_pkg::PH_BODY;
      end
      afd_pkg::PH_BODY: begin
        if (body_count == 16'd0) begin
          frame_kind_next = b;
        end
        running_sum_next = running_sum + b;
        body_count_next  = count_inc;
        has_result       = 1'b1;
        if (count_inc == frame_length) begin
          phase_next = afd_pkg::PH_CSUM;
        end
      end
      afd_pkg::PH_CSUM: begin
        // checksum failure wins, then empty, then unknown type
        if (running_sum + b != afd_pkg::SUM_TARGET) begin
          status = afd_pkg::ST_CSUM;
        end else if (frame_length == 16'd0) begin
          status = afd_pkg::ST_EMPTY;
        end else if (!afd_pkg::kind_known(frame_kind)) begin
          status = afd_pkg::ST_UNKNOWN;
        end else begin
          status = afd_pkg::ST_OK;
        end
        has_result = 1'b1;
        end_result = 1'b1;
        phase_next = afd_pkg::PH_HUNT;
      end
      default: begin
        phase_next = (b == afd_pkg::START_BYTE) ? afd_pkg::PH_LENHI : afd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= afd_pkg::PH_HUNT;
      frame_length <= '0;
      body_count   <= '0;
      running_sum  <= '0;
      frame_kind   <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      body_count   <= body_count_next;
      running_sum  <= running_sum_next;
      frame_kind   <= frame_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_result;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      data_byte    <= b;
      byte_index   <= body_count;
      frame_end    <= end_result;
      frame_status <= status;
    end
  end

  assign res.valid        = out_valid;
  assign res.data_byte    = data_byte;
  assign res.byte_index   = byte_index;
  assign res.frame_end    = frame_end;
  assign res.frame_status = frame_status;

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= afd_pkg::PH_CSUM)
    else $error("parse phase left the defined codes");

  a_body_bound: assert property (@(posedge clk) disable iff (rst)
    phase == afd_pkg::PH_BODY |-> body_count < frame_length)
    else $error("body count reached frame length inside the body");

  a_body_status_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> frame_status == afd_pkg::ST_OK)
    else $error("body byte carries a nonzero status");

  a_empty_to_csum: assert property (@(posedge clk) disable iff (rst)
    advance && phase == afd_pkg::PH_LENLO && full_length == 16'd0
    |=> phase == afd_pkg::PH_CSUM)
    else $error("empty frame did not go to checksum");

  a_stall_no_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ready |-> !advance)
    else $error("parser advanced while a result was stalled");

endmodule
`default_nettype wire

[design/api_frame_deframer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// api_frame_deframer_unit
// Serial API frame receiver: hunts for the start byte, reads the 16-bit
// length, streams body bytes with their index and ends each frame with a
// checksum/type status word.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                            Handshake
// rx       in   rx_byte[7:0]                                       valid/ready
// result   out  data_byte[7:0] byte_index[15:0] frame_end frame_status[1:0]
//                                                                  valid/ready
//
// One byte per cycle sustained while result is ready; an accepted rx byte reaches
// a result word through the input register, then the result register.
// Hunting and header bytes produce no result word.
// Reset (rst, synchronous) returns the parser to hunting and empties both
// registers.
// A stalled result word holds the held input byte; rx keeps accepting while
// the input register is free.
// ----------------------------------------------------------------------------
module api_frame_deframer_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  afd_byte_if.sink     rx,
  afd_result_if.source result
);

  afd_pkg::byte_word_t word;
  logic                advance;

  afd_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .word    (word)
  );

  afd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .word    (word),
    .advance (advance),
    .res     (result)
  );

endmodule
`default_nettype wire
